// File: design/gbs_pkg.sv
`timescale 1ns / 1ps
// gbs_pkg: shared constants and types of the 3x3 gaussian blur stream core
// no dependencies; imported by the channel interfaces, the top level and gbs_window
package gbs_pkg;

    // frame geometry limits
    localparam int MAX_WIDTH  = 128;
    localparam int MAX_HEIGHT = 4096;

    // field and counter widths
    localparam int PIX_W    = 8;
    localparam int SUM_W    = 12;
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int WIDTH_W  = 8;
    localparam int HEIGHT_W = 13;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W    = 13;
    localparam int CSUM_W   = PIX_W + 2;

    // row store word: far row in the upper half, near row in the lower half
    localparam int ROW_WORD_W = 2 * PIX_W;

    localparam logic [WIDTH_W-1:0]  MAX_WIDTH_V  = WIDTH_W'(MAX_WIDTH);
    localparam logic [HEIGHT_W-1:0] MAX_HEIGHT_V = HEIGHT_W'(MAX_HEIGHT);

    // input item opcodes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_idx;

    // one window column, top to bottom
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } t_column;

    // control of the item in the row-store read stage
    typedef struct packed {
        logic             valid;
        logic             col_zero;
        logic             top_en;
        logic             mid_en;
        logic             emit;
        logic             last;
        logic [COL_W-1:0] addr;
        logic [PIX_W-1:0] bot;
    } t_s1_ctl;

endpackage

// File: design/gbs_pix_if.sv
`timescale 1ns / 1ps
// gbs_pix_if: input pixel channel, valid/ready with op and pixel payload
// depends on gbs_pkg
interface gbs_pix_if
    import gbs_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             op;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output op, output pixel, input ready);
    modport sink   (input valid, input op, input pixel, output ready);
endinterface

// File: design/gbs_res_if.sv
`timescale 1ns / 1ps
// gbs_res_if: result channel, valid/ready with blurred sum and frame end flag
// depends on gbs_pkg
interface gbs_res_if
    import gbs_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [SUM_W-1:0] blurred_times_sixteen;
    logic             last_of_frame;

    modport source (output valid, output blurred_times_sixteen, output last_of_frame,
                    input ready);
    modport sink   (input valid, input blurred_times_sixteen, input last_of_frame,
                    output ready);
endinterface

// File: design/gaussian_blur_3x3_stream_core.sv
`timescale 1ns / 1ps
// gaussian_blur_3x3_stream_core: streaming zero-padded 3x3 gaussian blur
// depends on gbs_pkg, gbs_pix_if, gbs_res_if, gbs_row_ram, gbs_window
//
//   channel   dir  handshake        payload
//   i_pix     in   valid/ready      op, pixel
//   o_res     out  valid/ready      blurred_times_sixteen, last_of_frame
//   i_cfg     in   i_cfg_we         i_cfg_idx, i_cfg_data
//
// one item per cycle sustained while the output is not stalled; the item that causes a
// result passes the row store read stage, then its window sum enters the output register
// the single-port-pair row store is read and written once per item
// synchronous active-low reset; no clearing pass, the row store is masked by row
// ready drops only while a result is held in the stage and the output is stalled
module gaussian_blur_3x3_stream_core
    import gbs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    gbs_pix_if.sink              i_pix,
    gbs_res_if.source            o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);
    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;
    logic [COL_W-1:0]    r_ic;
    logic [HEIGHT_W-1:0] r_ir;
    t_s1_ctl             r_s1;
    logic                r_out_valid;
    logic [SUM_W-1:0]    r_out_sum;
    logic                r_out_last;

    logic                  accept;
    logic                  in_frame;
    logic                  proceed;
    logic                  s0_last;
    logic                  row_end;
    logic                  out_free;
    logic                  s1_adv;
    logic                  s1_step;
    logic [ROW_WORD_W-1:0] row_word;
    logic [SUM_W-1:0]      win_sum;
    logic [WIDTH_W-1:0]    n_width;
    logic [HEIGHT_W-1:0]   n_height;
    logic [WIDTH_W-1:0]    cfg_w;
    logic [HEIGHT_W-1:0]   cfg_h;

    // handshake between input, read stage and output register
    assign out_free    = !r_out_valid || o_res.ready;
    assign s1_adv      = !r_s1.emit || out_free;
    assign s1_step     = r_s1.valid && s1_adv;
    assign i_pix.ready = !r_s1.valid || s1_adv;
    assign accept      = i_pix.valid && i_pix.ready;

    // drain ticks inside the frame are dropped
    assign in_frame = r_ir < r_height;
    assign proceed  = accept && !(in_frame && (i_pix.op == OP_DRAIN));
    assign s0_last  = (r_ir == r_height + HEIGHT_W'(1)) && (r_ic == '0);
    assign row_end  = ({1'b0, r_ic} == r_width - WIDTH_W'(1));

    // register value clamping
    always_comb begin
        cfg_w = i_cfg_data[WIDTH_W-1:0];
        cfg_h = i_cfg_data[HEIGHT_W-1:0];
        if (cfg_w == '0) begin
            cfg_w = WIDTH_W'(1);
        end else if (cfg_w > MAX_WIDTH_V) begin
            cfg_w = MAX_WIDTH_V;
        end
        if (cfg_h == '0) begin
            cfg_h = HEIGHT_W'(1);
        end else if (cfg_h > MAX_HEIGHT_V) begin
            cfg_h = MAX_HEIGHT_V;
        end
    end

    // register write decode
    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_WIDTH:  n_width  = cfg_w;
                CFG_HEIGHT: n_height = cfg_h;
                default: begin
                    n_width  = r_width;
                    n_height = r_height;
                end
            endcase
        end
    end

    // configuration and position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= MAX_WIDTH_V;
            r_height <= HEIGHT_W'(128);
            r_ic     <= '0;
            r_ir     <= '0;
        end else begin
            r_width  <= n_width;
            r_height <= n_height;
            if (i_cfg_we) begin
                r_ic <= '0;
                r_ir <= '0;
            end else if (proceed) begin
                if (s0_last) begin
                    r_ic <= '0;
                    r_ir <= '0;
                end else if (row_end) begin
                    r_ic <= '0;
                    r_ir <= r_ir + HEIGHT_W'(1);
                end else begin
                    r_ic <= r_ic + COL_W'(1);
                end
            end
        end
    end

    // read stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else if (i_pix.ready) begin
            r_s1.valid <= proceed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proceed) begin
            r_s1.col_zero <= (r_ic == '0);
            r_s1.top_en   <= (r_ir >= HEIGHT_W'(2)) && (r_ir <= r_height + HEIGHT_W'(1));
            r_s1.mid_en   <= (r_ir >= HEIGHT_W'(1)) && (r_ir <= r_height);
            r_s1.emit     <= (r_ir >= HEIGHT_W'(2)) || ((r_ir == HEIGHT_W'(1)) && (r_ic != '0));
            r_s1.last     <= s0_last;
            r_s1.addr     <= r_ic;
            r_s1.bot      <= in_frame ? i_pix.pixel : '0;
        end
    end

    // row store: far row moves up from near, near takes the new pixel
    gbs_row_ram #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (ROW_WORD_W)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (s1_step),
        .i_waddr (r_s1.addr),
        .i_wdata ({row_word[PIX_W-1:0], r_s1.bot}),
        .i_re    (proceed),
        .i_raddr (r_ic),
        .o_rdata (row_word)
    );

    gbs_window u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (s1_step),
        .i_ctl      (r_s1),
        .i_row_word (row_word),
        .o_sum      (win_sum)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_step && r_s1.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_step && r_s1.emit) begin
            r_out_sum  <= win_sum;
            r_out_last <= r_s1.last;
        end
    end

    assign o_res.valid                 = r_out_valid;
    assign o_res.blurred_times_sixteen = r_out_sum;
    assign o_res.last_of_frame         = r_out_last;

`ifndef NO_ASSERTIONS
    // column counter stays inside the row
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_ic} < r_width))
        else $error("column counter outside the row");

    // the frame's final item restarts the position counters
    a_last_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proceed && s0_last && !i_cfg_we) |=> ((r_ic == '0) && (r_ir == '0)))
        else $error("counters not restarted after frame end");

    // input stalls only behind a held result and a stalled output
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix.ready |-> (r_s1.valid && r_s1.emit && r_out_valid && !o_res.ready))
        else $error("input stalled without cause");
`endif
endmodule

// File: design/gbs_row_ram.sv
`timescale 1ns / 1ps
// gbs_row_ram: generic single-clock ram, one write and one registered read port
// a read of the address written in the same cycle returns the new data
module gbs_row_ram #(
    parameter int DEPTH  = 128,
    parameter int DATA_W = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);
    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port with write forwarding
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if (i_we && (i_waddr == i_raddr)) begin
                r_rdata <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_raddr];
            end
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: design/gbs_window.sv
`timescale 1ns / 1ps
// gbs_window: 3x3 window registers, border masking and the weighted sum
// depends on gbs_pkg; fed by the row store read data of the top level
module gbs_window
    import gbs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  t_s1_ctl               i_ctl,
    input  logic [ROW_WORD_W-1:0] i_row_word,
    output logic [SUM_W-1:0]      o_sum
);
    t_column r_col [3];
    t_column new_col;
    t_column right_col;
    logic [CSUM_W-1:0] csum [3];

    // incoming column with rows outside the frame masked to zero
    always_comb begin
        new_col.top = i_ctl.top_en ? i_row_word[ROW_WORD_W-1:PIX_W] : '0;
        new_col.mid = i_ctl.mid_en ? i_row_word[PIX_W-1:0] : '0;
        new_col.bot = i_ctl.bot;
    end

    // first column of a row: output is for the previous row's right edge
    assign right_col = i_ctl.col_zero ? '0 : new_col;

    // column sums with vertical weights 1 2 1
    always_comb begin
        csum[0] = CSUM_W'(r_col[1].top) + {1'b0, r_col[1].mid, 1'b0} + CSUM_W'(r_col[1].bot);
        csum[1] = CSUM_W'(r_col[2].top) + {1'b0, r_col[2].mid, 1'b0} + CSUM_W'(r_col[2].bot);
        csum[2] = CSUM_W'(right_col.top) + {1'b0, right_col.mid, 1'b0}
                + CSUM_W'(right_col.bot);
    end

    // horizontal weights 1 2 1
    assign o_sum = SUM_W'(csum[0]) + {1'b0, csum[1], 1'b0} + SUM_W'(csum[2]);

    // window shift, cleared at the start of each row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col[0] <= '0;
            r_col[1] <= '0;
            r_col[2] <= '0;
        end else if (i_step) begin
            if (i_ctl.col_zero) begin
                r_col[0] <= '0;
                r_col[1] <= '0;
            end else begin
                r_col[0] <= r_col[1];
                r_col[1] <= r_col[2];
            end
            r_col[2] <= new_col;
        end
    end
endmodule
